>>> design/mi3_pkg.sv
`default_nettype none

package mi3_pkg;

   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int NUM_ELEM           = 9;

   // cofactor c[k] = e[COF_A]*e[COF_B] - e[COF_C]*e[COF_D], k row-major
   localparam int COF_A [NUM_ELEM] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
   localparam int COF_B [NUM_ELEM] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
   localparam int COF_C [NUM_ELEM] = '{5, 3, 4, 1, 6, 0, 4, 0, 3};
   localparam int COF_D [NUM_ELEM] = '{7, 8, 6, 8, 2, 7, 2, 5, 1};

   // result lane k takes the cofactor at the transposed place
   localparam int TRANSPOSE [NUM_ELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   typedef struct packed {
      logic valid;
      logic singular;
   } mi3_ctl_type;

   function automatic int cof_width(input int w);
      return 2 * w + 1;
   endfunction

   function automatic int det_width(input int w);
      return 3 * w + 3;
   endfunction

   function automatic int rem_width(input int w, input int f);
      return 2 * w + 1 + 2 * f;
   endfunction

   function automatic int cmp_width(input int w, input int f);
      int a;
      int b;
      a = det_width(w) + w;
      b = rem_width(w, f);
      return ((a > b) ? a : b) + 1;
   endfunction

endpackage

`default_nettype wire

>>> design/mi3_cofactor.sv
`default_nettype none

module mi3_cofactor import mi3_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire mi3_ctl_type                  src_ctl,
   input  wire logic signed [WORD_WIDTH-1:0] src_elem [NUM_ELEM],
   output mi3_ctl_type                       dst_ctl,
   output logic signed [WORD_WIDTH-1:0]      dst_elem [NUM_ELEM],
   output logic signed [2*WORD_WIDTH:0]      dst_cof  [NUM_ELEM]
);

   localparam int PW = 2 * WORD_WIDTH;
   localparam int CW = cof_width(WORD_WIDTH);

   mi3_ctl_type                 ctl1_ff, ctl2_ff;
   logic signed [PW-1:0]         prod_a_ff [NUM_ELEM];
   logic signed [PW-1:0]         prod_b_ff [NUM_ELEM];
   logic signed [WORD_WIDTH-1:0] elem1_ff  [NUM_ELEM];
   logic signed [WORD_WIDTH-1:0] elem2_ff  [NUM_ELEM];
   logic signed [CW-1:0]         cof_ff    [NUM_ELEM];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (en) begin
         ctl1_ff <= src_ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            prod_a_ff[k] <= PW'(src_elem[COF_A[k]]) * PW'(src_elem[COF_B[k]]);
            prod_b_ff[k] <= PW'(src_elem[COF_C[k]]) * PW'(src_elem[COF_D[k]]);
            elem1_ff[k]  <= src_elem[k];
            cof_ff[k]    <= CW'(prod_a_ff[k]) - CW'(prod_b_ff[k]);
            elem2_ff[k]  <= elem1_ff[k];
         end
      end
   end

   assign dst_ctl  = ctl2_ff;
   assign dst_elem = elem2_ff;
   assign dst_cof  = cof_ff;

endmodule

`default_nettype wire

>>> design/mi3_det.sv
`default_nettype none

module mi3_det import mi3_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      en,
   input  wire mi3_ctl_type                               src_ctl,
   input  wire logic signed [WORD_WIDTH-1:0]              src_elem [NUM_ELEM],
   input  wire logic signed [2*WORD_WIDTH:0]              src_cof  [NUM_ELEM],
   output mi3_ctl_type                                    dst_ctl,
   output logic signed [WORD_WIDTH-1:0]                   dst_elem [NUM_ELEM],
   output logic [3*WORD_WIDTH+2:0]                        dst_den,
   output logic [2*WORD_WIDTH+2*FRAC_BITS:0]              dst_rem  [NUM_ELEM],
   output logic                                           dst_neg  [NUM_ELEM]
);

   localparam int W  = WORD_WIDTH;
   localparam int CW = cof_width(W);
   localparam int LW = 2 * W + 1;
   localparam int TW = 3 * W + 1;
   localparam int DW = det_width(W);
   localparam int RW = rem_width(W, FRAC_BITS);

   mi3_ctl_type          ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [LW-1:0] lo_ff   [3];
   logic signed [LW-1:0] hi_ff   [3];
   logic signed [TW-1:0] term_ff [3];
   logic signed [DW-1:0] det_ff;
   logic [DW-1:0]        den_ff;
   logic [RW-1:0]        rem_ff  [NUM_ELEM];
   logic                 neg_ff  [NUM_ELEM];
   logic signed [W-1:0]  elem1_ff [NUM_ELEM];
   logic signed [W-1:0]  elem2_ff [NUM_ELEM];
   logic signed [W-1:0]  elem3_ff [NUM_ELEM];
   logic signed [W-1:0]  elem4_ff [NUM_ELEM];
   logic signed [CW-1:0] cof1_ff  [NUM_ELEM];
   logic signed [CW-1:0] cof2_ff  [NUM_ELEM];
   logic signed [CW-1:0] cof3_ff  [NUM_ELEM];
   logic [CW-1:0]        cmag     [NUM_ELEM];
   logic                 csign    [NUM_ELEM];

   always_comb begin
      logic signed [CW-1:0] cof_t;
      for (int k = 0; k < NUM_ELEM; k++) begin
         cof_t    = cof3_ff[TRANSPOSE[k]];
         csign[k] = cof_t[CW-1];
         cmag[k]  = cof_t[CW-1] ? CW'(-cof_t) : CW'(cof_t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (en) begin
         ctl1_ff <= src_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= '{valid: ctl3_ff.valid, singular: (det_ff == '0)};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // row 0 times its cofactors, each cofactor split into a low and a high half
         for (int j = 0; j < 3; j++) begin
            lo_ff[j]   <= LW'(src_elem[j]) * LW'($signed({1'b0, src_cof[j][W-1:0]}));
            hi_ff[j]   <= LW'(src_elem[j]) * LW'($signed(src_cof[j][CW-1:W]));
            term_ff[j] <= TW'(lo_ff[j]) + (TW'(hi_ff[j]) <<< W);
         end
         det_ff <= DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
         den_ff <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         for (int k = 0; k < NUM_ELEM; k++) begin
            elem1_ff[k] <= src_elem[k];
            elem2_ff[k] <= elem1_ff[k];
            elem3_ff[k] <= elem2_ff[k];
            elem4_ff[k] <= elem3_ff[k];
            cof1_ff[k]  <= src_cof[k];
            cof2_ff[k]  <= cof1_ff[k];
            cof3_ff[k]  <= cof2_ff[k];
            rem_ff[k]   <= RW'(cmag[k]) << (2 * FRAC_BITS);
            neg_ff[k]   <= csign[k] ^ det_ff[DW-1];
         end
      end
   end

   assign dst_ctl  = ctl4_ff;
   assign dst_elem = elem4_ff;
   assign dst_den  = den_ff;
   assign dst_rem  = rem_ff;
   assign dst_neg  = neg_ff;

endmodule

`default_nettype wire

>>> design/mi3_div_stage.sv
`default_nettype none

module mi3_div_stage import mi3_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
   parameter int SHIFT      = WORD_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire mi3_ctl_type                         src_ctl,
   input  wire logic signed [WORD_WIDTH-1:0]        src_elem [NUM_ELEM],
   input  wire logic [3*WORD_WIDTH+2:0]             src_den,
   input  wire logic [2*WORD_WIDTH+2*FRAC_BITS:0]   src_rem  [NUM_ELEM],
   input  wire logic                                src_neg  [NUM_ELEM],
   input  wire logic [WORD_WIDTH-1:0]               src_quo  [NUM_ELEM],
   input  wire logic                                src_ovf  [NUM_ELEM],
   output mi3_ctl_type                              dst_ctl,
   output logic signed [WORD_WIDTH-1:0]             dst_elem [NUM_ELEM],
   output logic [3*WORD_WIDTH+2:0]                  dst_den,
   output logic [2*WORD_WIDTH+2*FRAC_BITS:0]        dst_rem  [NUM_ELEM],
   output logic                                     dst_neg  [NUM_ELEM],
   output logic [WORD_WIDTH-1:0]                    dst_quo  [NUM_ELEM],
   output logic                                     dst_ovf  [NUM_ELEM]
);

   localparam int W  = WORD_WIDTH;
   localparam int DW = det_width(W);
   localparam int RW = rem_width(W, FRAC_BITS);
   localparam int XW = cmp_width(W, FRAC_BITS);

   mi3_ctl_type         ctl_ff;
   logic signed [W-1:0] elem_ff [NUM_ELEM];
   logic [DW-1:0]       den_ff;
   logic [RW-1:0]       rem_ff  [NUM_ELEM];
   logic                neg_ff  [NUM_ELEM];
   logic [W-1:0]        quo_ff  [NUM_ELEM];
   logic                ovf_ff  [NUM_ELEM];
   logic [XW-1:0]       shifted;
   logic [XW-1:0]       diff    [NUM_ELEM];
   logic                geq     [NUM_ELEM];

   always_comb begin
      shifted = XW'(src_den) << SHIFT;
      for (int k = 0; k < NUM_ELEM; k++) begin
         geq[k]  = XW'(src_rem[k]) >= shifted;
         diff[k] = XW'(src_rem[k]) - shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= src_ctl;
      end
   end

   generate
      if (SHIFT >= W) begin : g_range
         // quotient would need more than WORD_WIDTH bits: flag it, no subtract
         always_ff @(posedge clock) begin
            if (en) begin
               for (int k = 0; k < NUM_ELEM; k++) begin
                  rem_ff[k] <= src_rem[k];
                  quo_ff[k] <= src_quo[k];
                  ovf_ff[k] <= src_ovf[k] | geq[k];
               end
            end
         end
      end else begin : g_bit
         always_ff @(posedge clock) begin
            if (en) begin
               for (int k = 0; k < NUM_ELEM; k++) begin
                  rem_ff[k] <= geq[k] ? RW'(diff[k]) : src_rem[k];
                  quo_ff[k] <= src_quo[k] | (W'(geq[k]) << SHIFT);
                  ovf_ff[k] <= src_ovf[k];
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= src_den;
         for (int k = 0; k < NUM_ELEM; k++) begin
            elem_ff[k] <= src_elem[k];
            neg_ff[k]  <= src_neg[k];
         end
      end
   end

   assign dst_ctl  = ctl_ff;
   assign dst_elem = elem_ff;
   assign dst_den  = den_ff;
   assign dst_rem  = rem_ff;
   assign dst_neg  = neg_ff;
   assign dst_quo  = quo_ff;
   assign dst_ovf  = ovf_ff;

endmodule

`default_nettype wire

>>> design/matrix3_inverse.sv
`default_nettype none

// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// One matrix is taken per request, nine elements row by row in req_tdata, and one
// result comes back per request in order: each element is the exact cofactor over
// the exact determinant, truncated toward zero and clamped to the word range
// (rsp_tuser bit 1 set on any clamp). A matrix with a zero determinant comes back
// unchanged with rsp_tuser bit 0 set. A new request is taken every cycle while
// req_tready is high; the pipeline is the two cofactor stages, four determinant
// stages, one restoring-divider stage per quotient bit plus a range-check stage,
// the final select stage and the output register. A two-entry output buffer keeps
// req_tready a register so the input keeps flowing while one result waits.
module matrix3_inverse import mi3_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22, zero fill
   input  wire logic [((9*WORD_WIDTH+7)/8)*8-1:0]          req_tdata,
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero fill
   output logic [((9*WORD_WIDTH+7)/8)*8-1:0]               rsp_tdata,
   // singular, saturated
   output logic [1:0]                                      rsp_tuser
);

   localparam int W   = WORD_WIDTH;
   localparam int NW  = NUM_ELEM * W;
   localparam int TDW = ((NW + 7) / 8) * 8;
   localparam int CW  = cof_width(W);
   localparam int DW  = det_width(W);
   localparam int RW  = rem_width(W, FRAC_BITS);
   localparam int NS  = W + 2;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   logic                en;
   mi3_ctl_type         src_ctl;
   logic signed [W-1:0] src_elem [NUM_ELEM];

   mi3_ctl_type          ctl_c;
   logic signed [W-1:0]  elem_c [NUM_ELEM];
   logic signed [CW-1:0] cof_c  [NUM_ELEM];

   mi3_ctl_type         ctl_d  [NS];
   logic signed [W-1:0] elem_d [NS][NUM_ELEM];
   logic [DW-1:0]       den_d  [NS];
   logic [RW-1:0]       rem_d  [NS][NUM_ELEM];
   logic                neg_d  [NS][NUM_ELEM];
   logic [W-1:0]        quo_d  [NS][NUM_ELEM];
   logic                ovf_d  [NS][NUM_ELEM];

   logic [NW-1:0]       fin_data_in;
   logic                fin_sat_in;
   logic                fin_valid_ff;
   logic [NW-1:0]       fin_data_ff;
   logic [1:0]          fin_user_ff;
   logic                out_valid_ff;
   logic [NW-1:0]       out_data_ff;
   logic [1:0]          out_user_ff;
   logic                skid_valid_ff;
   logic [NW-1:0]       skid_data_ff;
   logic [1:0]          skid_user_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      src_ctl.valid    = req_tvalid;
      src_ctl.singular = 1'b0;
      for (int k = 0; k < NUM_ELEM; k++) begin
         src_elem[k] = $signed(req_tdata[k*W +: W]);
      end
   end

   mi3_cofactor #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_cofactor (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .src_ctl  (src_ctl),
      .src_elem (src_elem),
      .dst_ctl  (ctl_c),
      .dst_elem (elem_c),
      .dst_cof  (cof_c)
   );

   mi3_det #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_det (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .src_ctl  (ctl_c),
      .src_elem (elem_c),
      .src_cof  (cof_c),
      .dst_ctl  (ctl_d[0]),
      .dst_elem (elem_d[0]),
      .dst_den  (den_d[0]),
      .dst_rem  (rem_d[0]),
      .dst_neg  (neg_d[0])
   );

   assign quo_d[0] = '{default: '0};
   assign ovf_d[0] = '{default: 1'b0};

   // stage s settles quotient bit WORD_WIDTH - s; the first one checks range only
   for (genvar s = 0; s < NS - 1; s++) begin : g_div
      mi3_div_stage #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS),
         .SHIFT      (W - s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .src_ctl  (ctl_d[s]),
         .src_elem (elem_d[s]),
         .src_den  (den_d[s]),
         .src_rem  (rem_d[s]),
         .src_neg  (neg_d[s]),
         .src_quo  (quo_d[s]),
         .src_ovf  (ovf_d[s]),
         .dst_ctl  (ctl_d[s+1]),
         .dst_elem (elem_d[s+1]),
         .dst_den  (den_d[s+1]),
         .dst_rem  (rem_d[s+1]),
         .dst_neg  (neg_d[s+1]),
         .dst_quo  (quo_d[s+1]),
         .dst_ovf  (ovf_d[s+1])
      );
   end

   always_comb begin
      logic [W-1:0] q;
      logic         sat;
      fin_sat_in = 1'b0;
      for (int k = 0; k < NUM_ELEM; k++) begin
         q   = quo_d[NS-1][k];
         sat = ovf_d[NS-1][k] |
               (neg_d[NS-1][k] ? (q[W-1] && (q[W-2:0] != '0)) : q[W-1]);
         fin_sat_in = fin_sat_in | sat;
         if (ctl_d[NS-1].singular) begin
            fin_data_in[k*W +: W] = elem_d[NS-1][k];
         end else if (sat) begin
            fin_data_in[k*W +: W] = neg_d[NS-1][k] ? MIN_VAL : MAX_VAL;
         end else begin
            fin_data_in[k*W +: W] = neg_d[NS-1][k] ? W'(-q) : q;
         end
      end
      if (ctl_d[NS-1].singular) begin
         fin_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= ctl_d[NS-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_data_ff <= fin_data_in;
         fin_user_ff <= {fin_sat_in, ctl_d[NS-1].singular};
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff  <= skid_valid_ff || fin_valid_ff;
         skid_valid_ff <= 1'b0;
      end else if (fin_valid_ff && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : fin_data_ff;
         out_user_ff <= skid_valid_ff ? skid_user_ff : fin_user_ff;
      end else if (fin_valid_ff && en) begin
         skid_data_ff <= fin_data_ff;
         skid_user_ff <= fin_user_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDW'(out_data_ff);
   assign rsp_tuser  = out_user_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_singular_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> !rsp_tuser[1])
      else $error("singular result marked saturated");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      (!en && fin_valid_ff) |=> (fin_valid_ff && $stable(fin_data_ff)))
      else $error("pipeline tail moved during stall");

endmodule

`default_nettype wire
